>>> hw/rtl/lpfd_pkg.sv
package lpfd_pkg;

  localparam int MAC_REGS        = 4;
  localparam int MAC_W           = 48;
  localparam int LEN_W           = 16;
  localparam int MASK_W          = 4;
  localparam int BYTE_W          = 8;
  localparam int ADDR_W          = 6;
  localparam int DATA_W          = 64;
  localparam int HDR_BYTES       = 4;
  localparam int MAC_BYTES       = 6;
  localparam int GROUP_BIT       = 40;
  localparam int NUM_PORTS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd1518;

  localparam logic KIND_BYTE       = 1'b0;
  localparam logic KIND_LINK_RESET = 1'b1;

  typedef enum logic [2:0] {
    REG_MAC_ZERO,
    REG_MAC_ONE,
    REG_MAC_TWO,
    REG_MAC_THREE,
    REG_PORT_ENABLE,
    REG_LENGTH_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [MAC_REGS-1:0][MAC_W-1:0] mac;
    logic [MASK_W-1:0]              enable;
    logic [LEN_W-1:0]               limit;
  } cfg_t;

  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_length;
    logic              oversize;
    logic              mac_ok;
    logic [MAC_W-1:0]  dest_mac;
  } act_t;

endpackage

>>> hw/rtl/lpfd_if.sv
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, kind, byte_in, input ready);
  modport sink (input valid, kind, byte_in, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic [3:0]  deliver_mask;
  logic [15:0] frame_length;
  logic        oversize;

  modport source (output valid, data_valid, data_byte, frame_end, deliver_mask, frame_length,
                  oversize, input ready);
  modport sink (input valid, data_valid, data_byte, frame_end, deliver_mask, frame_length,
                oversize, output ready);
endinterface

>>> hw/rtl/length_prefixed_frame_deframer.sv
// Deframes a link byte stream in which every frame is preceded by a 4-byte little-endian
// length. Each frame byte leaves as one word; the word carrying the last byte also carries
// the frame length and a delivery mask with bit i set when port i is enabled and the
// destination MAC is group-addressed or equals the MAC of port i (frames under 6 bytes get
// an empty mask). A zero length gives one end word with no data; a length above the limit
// gives one oversize word and header collection restarts at the next byte. A link reset
// word clears the parse and gives no output. The block takes one word per clock: the parser
// handles each byte as it is taken, a QUEUE_DEPTH-entry queue feeds the MAC filter, whose
// four 48-bit compares run in parallel, and results pass through the queue into the
// output register. Ready on the link side drops only when the queue fills under
// output backpressure. Registers sit at byte address 8*i: port MACs 0..3, port enable mask,
// frame length limit (reset 1518); write them only while the block is idle.
module length_prefixed_frame_deframer #(
  parameter int NUM_PORTS   = lpfd_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = lpfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpfd_pkg::ADDR_W-1:0] paddr,
  input  logic [lpfd_pkg::DATA_W-1:0] pwdata,
  output logic [lpfd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  lpfd_in_if.sink                     link,
  lpfd_out_if.source                  frame
);
  import lpfd_pkg::*;

  cfg_t cfg;
  act_t push_entry;
  act_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  lpfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .link       (link),
    .limit      (cfg.limit),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  lpfd_back #(
    .NUM_PORTS (NUM_PORTS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .frame (frame)
  );

endmodule

>>> hw/rtl/lpfd_regs.sv
module lpfd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfd_pkg::ADDR_W-1:0]    paddr,
  input  logic [lpfd_pkg::DATA_W-1:0]    pwdata,
  output logic [lpfd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output lpfd_pkg::cfg_t                 cfg
);
  import lpfd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mac    <= '0;
      cfg.enable <= '0;
      cfg.limit  <= LIMIT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_MAC_ZERO:     cfg.mac[0] <= pwdata[MAC_W-1:0];
        REG_MAC_ONE:      cfg.mac[1] <= pwdata[MAC_W-1:0];
        REG_MAC_TWO:      cfg.mac[2] <= pwdata[MAC_W-1:0];
        REG_MAC_THREE:    cfg.mac[3] <= pwdata[MAC_W-1:0];
        REG_PORT_ENABLE:  cfg.enable <= pwdata[MASK_W-1:0];
        REG_LENGTH_LIMIT: cfg.limit  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAC_ZERO:     prdata = DATA_W'(cfg.mac[0]);
      REG_MAC_ONE:      prdata = DATA_W'(cfg.mac[1]);
      REG_MAC_TWO:      prdata = DATA_W'(cfg.mac[2]);
      REG_MAC_THREE:    prdata = DATA_W'(cfg.mac[3]);
      REG_PORT_ENABLE:  prdata = DATA_W'(cfg.enable);
      REG_LENGTH_LIMIT: prdata = DATA_W'(cfg.limit);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/lpfd_front.sv
module lpfd_front (
  input  logic                        clk,
  input  logic                        rst,
  lpfd_in_if.sink                     link,
  input  logic [lpfd_pkg::LEN_W-1:0]  limit,
  input  logic                        q_full,
  output logic                        push,
  output lpfd_pkg::act_t              push_entry
);
  import lpfd_pkg::*;

  logic                           in_payload, in_payload_next;
  logic [1:0]                     hdr_count, hdr_count_next;
  logic [(HDR_BYTES-1)*BYTE_W-1:0] len_acc, len_acc_next;
  logic [LEN_W-1:0]               remaining, remaining_next;
  logic [LEN_W-1:0]               seen, seen_next;
  logic [MAC_W-1:0]               dest, dest_next;
  logic [HDR_BYTES*BYTE_W-1:0]    len_full;
  logic                           accept;

  assign link.ready = !q_full;
  assign accept     = link.valid && link.ready;
  assign len_full   = {link.byte_in, len_acc};

  always_comb begin
    in_payload_next = in_payload;
    hdr_count_next  = hdr_count;
    len_acc_next    = len_acc;
    remaining_next  = remaining;
    seen_next       = seen;
    dest_next       = dest;
    push            = 1'b0;
    push_entry      = '0;
    if (accept) begin
      if (link.kind == KIND_LINK_RESET) begin
        in_payload_next = 1'b0;
        hdr_count_next  = '0;
        len_acc_next    = '0;
        remaining_next  = '0;
        seen_next       = '0;
        dest_next       = '0;
      end else if (!in_payload) begin
        hdr_count_next = hdr_count + 2'd1;
        unique case (hdr_count)
          2'd0: len_acc_next[7:0]   = link.byte_in;
          2'd1: len_acc_next[15:8]  = link.byte_in;
          2'd2: len_acc_next[23:16] = link.byte_in;
          default: begin
            len_acc_next   = '0;
            hdr_count_next = '0;
            if (len_full > 32'(limit)) begin
              push                    = 1'b1;
              push_entry.oversize     = 1'b1;
              push_entry.frame_length = (len_full[31:16] != '0) ? '1 : len_full[15:0];
            end else if (len_full == '0) begin
              push                 = 1'b1;
              push_entry.frame_end = 1'b1;
            end else begin
              in_payload_next = 1'b1;
              remaining_next  = len_full[LEN_W-1:0];
            end
          end
        endcase
      end else begin
        if (seen < LEN_W'(MAC_BYTES)) begin
          dest_next = {dest[MAC_W-BYTE_W-1:0], link.byte_in};
        end
        seen_next             = seen + 1'b1;
        remaining_next        = remaining - 1'b1;
        push                  = 1'b1;
        push_entry.data_valid = 1'b1;
        push_entry.data_byte  = link.byte_in;
        if (remaining == LEN_W'(1)) begin
          push_entry.frame_end    = 1'b1;
          push_entry.frame_length = seen_next;
          push_entry.mac_ok       = seen_next >= LEN_W'(MAC_BYTES);
          push_entry.dest_mac     = dest_next;
          in_payload_next         = 1'b0;
          remaining_next          = '0;
          seen_next               = '0;
          dest_next               = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      hdr_count  <= '0;
      len_acc    <= '0;
      remaining  <= '0;
      seen       <= '0;
      dest       <= '0;
    end else begin
      in_payload <= in_payload_next;
      hdr_count  <= hdr_count_next;
      len_acc    <= len_acc_next;
      remaining  <= remaining_next;
      seen       <= seen_next;
      dest       <= dest_next;
    end
  end

  a_oversize_no_data: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.oversize |-> !push_entry.data_valid && !push_entry.frame_end)
    else $error("oversize word carries data");

endmodule

>>> hw/rtl/lpfd_queue.sv
module lpfd_queue #(
  parameter int DEPTH = lpfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpfd_pkg::act_t push_entry,
  input  logic           pop,
  output lpfd_pkg::act_t head,
  output logic           full,
  output logic           empty
);
  import lpfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  act_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

>>> hw/rtl/lpfd_back.sv
module lpfd_back #(
  parameter int NUM_PORTS = lpfd_pkg::NUM_PORTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lpfd_pkg::cfg_t cfg,
  input  lpfd_pkg::act_t head,
  input  logic           empty,
  output logic           pop,
  lpfd_out_if.source     frame
);
  import lpfd_pkg::*;

  logic [MASK_W-1:0] mask;
  logic              group;

  assign pop   = !empty && (!frame.valid || frame.ready);
  assign group = head.dest_mac[GROUP_BIT];

  always_comb begin
    mask = '0;
    if (head.frame_end && head.mac_ok) begin
      for (int i = 0; i < MAC_REGS; i++) begin
        if (i < NUM_PORTS && cfg.enable[i] && (group || head.dest_mac == cfg.mac[i])) begin
          mask[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (pop) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame.data_valid   <= head.data_valid;
      frame.data_byte    <= head.data_byte;
      frame.frame_end    <= head.frame_end;
      frame.deliver_mask <= mask;
      frame.frame_length <= head.frame_length;
      frame.oversize     <= head.oversize;
    end
  end

  a_mask_on_end: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.deliver_mask != '0 |-> frame.frame_end && frame.data_valid)
    else $error("delivery mask outside frame end");

endmodule

>>> test/tb_length_prefixed_frame_deframer.sv
`timescale 1ns / 100ps

module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int REPORT_MAX = 10;
  localparam logic [MAC_W-1:0] MAC_A = 48'h02_11_22_33_44_55;
  localparam logic [MAC_W-1:0] GROUP_FLAG = 48'h1 << GROUP_BIT;

  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic [MASK_W-1:0] deliver_mask;
    logic [LEN_W-1:0]  frame_length;
    logic              oversize;
  } frame_word_t;

  class frame_scoreboard;
    logic [MAC_W-1:0]  port_mac [MAC_REGS];
    logic [MASK_W-1:0] port_enable;
    logic [LEN_W-1:0]  length_limit;
    logic              in_payload;
    logic [2:0]        hdr_count;
    logic [31:0]       len_acc;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  seen;
    logic [MAC_W-1:0]  dest_mac;
    frame_word_t       expected_words[$];
    int                errors;

    function new();
      foreach (port_mac[i]) port_mac[i] = '0;
      port_enable = '0;
      length_limit = LIMIT_RESET;
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      in_payload = 1'b0;
      hdr_count = '0;
      len_acc = '0;
      remaining = '0;
      seen = '0;
      dest_mac = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_PORT_ENABLE: port_enable = value[MASK_W-1:0];
        REG_LENGTH_LIMIT: length_limit = value[LEN_W-1:0];
        default: port_mac[idx] = value[MAC_W-1:0];
      endcase
    endfunction

    function logic [MASK_W-1:0] delivery_ports();
      logic [MASK_W-1:0] ports;
      logic              group;
      ports = '0;
      group = dest_mac[GROUP_BIT];
      if (seen < LEN_W'(MAC_BYTES)) return '0;
      for (int i = 0; i < NUM_PORTS_DEF && i < MAC_REGS; i++) begin
        if (port_enable[i] && (group || dest_mac == port_mac[i])) ports[i] = 1'b1;
      end
      return ports;
    endfunction

    function void push_word(logic dv, logic [7:0] db, logic fe, logic [3:0] dm,
                            logic [15:0] fl, logic ov);
      expected_words.push_back({dv, db, fe, dm, fl, ov});
    endfunction

    function void note_byte(logic kind, logic [7:0] b);
      logic [31:0]      hdr_len;
      logic [MASK_W-1:0] ports;
      if (kind == KIND_LINK_RESET) begin
        clear_parse();
        return;
      end
      if (!in_payload) begin
        len_acc = len_acc | (32'(b) << (8 * hdr_count[1:0]));
        hdr_count = hdr_count + 3'd1;
        if (hdr_count < 3'(HDR_BYTES)) return;
        hdr_len = len_acc;
        clear_parse();
        if (hdr_len > 32'(length_limit)) begin
          push_word(1'b0, 8'h00, 1'b0, 4'h0,
                    (hdr_len > 32'hFFFF) ? 16'hFFFF : hdr_len[15:0], 1'b1);
        end else if (hdr_len == 0) begin
          push_word(1'b0, 8'h00, 1'b1, 4'h0, 16'h0000, 1'b0);
        end else begin
          in_payload = 1'b1;
          remaining = hdr_len[15:0];
        end
        return;
      end
      if (seen < LEN_W'(MAC_BYTES)) dest_mac = {dest_mac[MAC_W-9:0], b};
      if (seen != 16'hFFFF) seen = seen + 16'd1;
      if (remaining != 0) remaining = remaining - 16'd1;
      if (remaining == 0) begin
        ports = delivery_ports();
        push_word(1'b1, b, 1'b1, ports, seen, 1'b0);
        clear_parse();
      end else begin
        push_word(1'b1, b, 1'b0, 4'h0, 16'h0000, 1'b0);
      end
    endfunction

    function string word_text(frame_word_t w);
      return $sformatf("dv=%0d byte=%02h end=%0d mask=%h len=%0d oversize=%0d",
                       w.data_valid, w.data_byte, w.frame_end, w.deliver_mask,
                       w.frame_length, w.oversize);
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("unexpected word: %s", word_text(got));
        return;
      end
      want = expected_words.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("word mismatch: expected %s", word_text(want));
          $display("               actual   %s", word_text(got));
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lpfd_in_if  link_if ();
  lpfd_out_if frame_if ();

  frame_scoreboard sb = new();
  int  items_sent = 0;
  int  burst_left = 0;
  bit  long_hold_req = 1'b0;

  length_prefixed_frame_deframer u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .link    (link_if),
    .frame   (frame_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_word(logic kind, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        link_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    link_if.valid <= 1'b1;
    link_if.kind <= kind;
    link_if.byte_in <= b;
    do @(posedge clk); while (!link_if.ready);
    sb.note_byte(kind, b);
    if (kind == KIND_BYTE) items_sent++;
  endtask

  // stop sending until every expected word is out, then let the pipeline settle
  task automatic wait_idle();
    link_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame();
    logic [31:0]      hdr_len;
    logic [MAC_W-1:0] dst;
    logic [7:0]       frame_bytes[$];
    int               r;
    int               cut;
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(KIND_BYTE, 8'($urandom));
      send_word(KIND_LINK_RESET, 8'($urandom));
    end
    r = $urandom_range(0, 18);
    if (r == 0) hdr_len = 0;
    else if (r <= 2) hdr_len = $urandom_range(1, 5);
    else if (r <= 14) hdr_len = $urandom_range(6, 24);
    else if (r <= 16) hdr_len = $urandom_range(25, 90);
    else if (r == 17) hdr_len = 32'(sb.length_limit) + 1;
    else hdr_len = $urandom | 32'h0001_0000;
    case ($urandom_range(0, 3))
      0: dst = sb.port_mac[$urandom_range(0, MAC_REGS - 1)];
      1: dst = rand_mac() | GROUP_FLAG;
      2: dst = '1;
      default: dst = rand_mac() & ~GROUP_FLAG;
    endcase
    for (int i = 0; i < HDR_BYTES; i++) frame_bytes.push_back(hdr_len[8*i +: 8]);
    if (hdr_len <= 32'(sb.length_limit)) begin
      for (int i = 0; i < int'(hdr_len); i++) begin
        frame_bytes.push_back(i < MAC_BYTES ? dst[MAC_W-1-8*i -: 8] : 8'($urandom));
      end
    end
    cut = frame_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, frame_bytes.size() - 1);
    for (int i = 0; i < cut; i++) send_word(KIND_BYTE, frame_bytes[i]);
    if (cut < frame_bytes.size()) send_word(KIND_LINK_RESET, 8'($urandom));
  endtask

  task automatic run_phase(int n, int hold_at);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if (hold_at > 0 && items_sent >= hold_at) begin
        long_hold_req = 1'b1;
        hold_at = 0;
      end
      send_frame();
    end
  endtask

  // output side
  initial begin
    frame_word_t got;
    int          mode;
    int          mode_left;
    int          hold_left;
    frame_if.ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && frame_if.valid && frame_if.ready) begin
        got = {frame_if.data_valid, frame_if.data_byte, frame_if.frame_end,
               frame_if.deliver_mask, frame_if.frame_length, frame_if.oversize};
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        frame_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: frame_if.ready <= 1'b1;
          1: frame_if.ready <= ($urandom_range(0, 3) != 0);
          default: frame_if.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((link_if.valid && link_if.ready) || (frame_if.valid && frame_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] directed_bytes[$];
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    link_if.valid <= 1'b0;
    link_if.kind <= KIND_BYTE;
    link_if.byte_in <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_write(REG_MAC_ZERO, 64'(MAC_A));
    apb_write(REG_MAC_ONE, 64'hFFFF_FFFF_FFFF);
    apb_write(REG_MAC_TWO, 64'h0);
    apb_write(REG_MAC_THREE, 64'(rand_mac() & ~GROUP_FLAG));
    apb_write(REG_PORT_ENABLE, 64'hF);
    apb_write(REG_LENGTH_LIMIT, 64'(LIMIT_RESET));

    // zero length, saturated oversize, one-byte frame, start of a header
    directed_bytes = '{8'h00, 8'h00, 8'h00, 8'h00,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h01, 8'h00, 8'h00, 8'h00, 8'hA5,
                       8'h07};
    foreach (directed_bytes[i]) send_word(KIND_BYTE, directed_bytes[i]);
    send_word(KIND_LINK_RESET, 8'hFF);
    // six-byte frame addressed to port 0
    directed_bytes = '{8'h06, 8'h00, 8'h00, 8'h00};
    for (int i = 0; i < MAC_BYTES; i++) directed_bytes.push_back(MAC_A[MAC_W-1-8*i -: 8]);
    foreach (directed_bytes[i]) send_word(KIND_BYTE, directed_bytes[i]);

    run_phase(110, items_sent + 40);

    wait_idle();
    apb_write(REG_PORT_ENABLE, 64'h0);
    apb_write(REG_LENGTH_LIMIT, 64'h0);
    run_phase(60, 0);

    wait_idle();
    apb_write(REG_MAC_ZERO, 64'hFFFF_FFFF_FFFF);
    apb_write(REG_MAC_ONE, 64'h0);
    apb_write(REG_PORT_ENABLE, 64'($urandom_range(1, 14)));
    apb_write(REG_LENGTH_LIMIT, 64'hFFFF);
    run_phase(120, 0);

    wait_idle();
    apb_write(REG_MAC_TWO, 64'(rand_mac() & ~GROUP_FLAG));
    apb_write(REG_MAC_THREE, 64'(rand_mac() & ~GROUP_FLAG));
    apb_write(REG_PORT_ENABLE, 64'h5);
    apb_write(REG_LENGTH_LIMIT, 64'd12);
    run_phase(120, 0);

    wait_idle();
    apb_write(REG_MAC_ZERO, 64'(rand_mac() & ~GROUP_FLAG));
    apb_write(REG_MAC_ONE, 64'(rand_mac()));
    apb_write(REG_PORT_ENABLE, 64'hF);
    apb_write(REG_LENGTH_LIMIT, 64'(LIMIT_RESET));
    run_phase(110, 0);

    wait_idle();
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
